// ===== src/lru_page_replacement_unit_defines.svh =====
// assertion macros for the lru page replacement unit
// expects clk_i and rst_ni in the scope of every use
`ifndef LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_UNIT_DEFINES_SVH

// property that must hold at every clock edge outside reset
`define LRU_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) else $error(msg);

// same-cycle implication
`define LRU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/lru_pkg.sv =====
// shared types and constants for the lru page replacement unit
// no dependencies
`default_nettype none

package lru_pkg;

  localparam int PageNumW  = 16;
  localparam int HitPosW   = 3;
  localparam int MissCntW  = 32;
  localparam int FramesW   = 4;
  localparam int ApbDataW  = 32;
  localparam int ApbAddrW  = 3;

  // register word index on the apb port
  localparam logic RegFramesInUse = 1'b0;

  localparam logic [FramesW-1:0] FramesInUseRst = FramesW'(8);

  typedef struct packed {
    logic [PageNumW-1:0] page_number;
  } lru_req_t;

  typedef struct packed {
    logic                hit;
    logic [HitPosW-1:0]  hit_position;
    logic                evicted_valid;
    logic [PageNumW-1:0] evicted_page;
    logic [MissCntW-1:0] miss_count;
  } lru_rsp_t;

  typedef enum logic {
    LRU_IDLE,
    LRU_SCAN
  } lru_state_e;

endpackage

`default_nettype wire

// ===== src/lru_stream_if.sv =====
// valid/ready stream channel carrying one payload struct per transaction
// payload type is given by the instantiating code, normally from lru_pkg
`default_nettype none

interface lru_stream_if #(
  parameter type PayloadT = logic
);
  logic    valid;
  logic    ready;
  PayloadT payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/lru_page_replacement_unit.sv =====
// lru page replacement unit: move-to-front recency stack held in a page memory
// depends on lru_pkg, lru_stream_if and lru_page_replacement_unit_defines.svh
//
//   channel   dir   handshake                   payload
//   req_i     in    valid/ready                 page_number
//   rsp_o     out   valid/ready, output reg     hit, hit_position, evicted_valid,
//                                               evicted_page, miss_count
//   apb       in    psel/penable/pwrite/pready  frames_in_use at byte address 0
//
// a transaction walks s stack positions:
//   hit at position p gives s = p + 1, a miss gives s = min(fill + 1, n)
//   so at most n positions; the single read port of the page memory sets this
// the walk reads one position a cycle and writes the shifted entry back behind it
// reset clears fill count and miss counter and sets frames_in_use to 8; memory needs no clearing
// a finished result waits in the output register; the walk only stalls on its last
// step when that register is still full
`default_nettype none

`include "lru_page_replacement_unit_defines.svh"

module lru_page_replacement_unit import lru_pkg::*; #(
  parameter int FRAMES    = 8,
  parameter int PAGE_BITS = 16
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [ApbAddrW-1:0] paddr,
  input  wire logic [ApbDataW-1:0] pwdata,
  output      logic [ApbDataW-1:0] prdata,
  output      logic                pready,
  lru_stream_if.sink               req_i,
  lru_stream_if.source             rsp_o
);

  localparam int IdxW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CntW    = $clog2(FRAMES + 1);
  localparam int PageExW = (PAGE_BITS > PageNumW) ? PAGE_BITS : PageNumW;
  localparam int PosExW  = (IdxW > HitPosW) ? IdxW : HitPosW;

  // clamp a frame count register value to 1..FRAMES
  function automatic logic [CntW-1:0] depth_of(input logic [FramesW-1:0] f);
    int v;
    v = int'(f);
    if (v < 1) v = 1;
    if (v > FRAMES) v = FRAMES;
    return CntW'(v);
  endfunction

  // control state
  lru_state_e          state_q, state_d;
  logic [FramesW-1:0]  frames_q;
  logic [CntW-1:0]     count_q;     // resident entries, always a prefix of the stack
  logic [MissCntW-1:0] misses_q;
  logic                out_valid_q;

  // walk datapath
  logic [IdxW-1:0]      idx_q;
  logic [IdxW-1:0]      last_q;
  logic [PAGE_BITS-1:0] page_q;
  logic [PAGE_BITS-1:0] carry_q;    // entry moving down into the current position
  lru_rsp_t             out_q;

  // page memory, one entry per recency position
  logic [PAGE_BITS-1:0] mem_q [FRAMES];
  logic [PAGE_BITS-1:0] rd_data_q;
  logic                 rd_en, wr_en;
  logic [IdxW-1:0]      rd_addr;

  logic [CntW-1:0]      n_act;
  logic [CntW-1:0]      last_cnt;
  logic [PageExW-1:0]   page_in_ex;
  logic [PageExW-1:0]   ev_ex;
  logic [PosExW-1:0]    pos_ex;
  logic                 pos_valid, match, at_last, fin, out_free, retire, evict;
  logic                 cfg_wr;

  assign n_act      = depth_of(frames_q);
  assign page_in_ex = PageExW'(req_i.payload.page_number);

  // last position the walk may need: the first free slot, or the bottom of the stack
  assign last_cnt = (count_q < n_act) ? count_q : n_act - 1'b1;

  assign pos_valid = CntW'(idx_q) < count_q;
  assign match     = pos_valid && (rd_data_q == page_q);
  assign at_last   = idx_q == last_q;
  assign fin       = match || at_last;
  assign out_free  = !out_valid_q || rsp_o.ready;
  assign retire    = (state_q == LRU_SCAN) && fin && out_free;
  // a miss that reaches a resident bottom entry pushes it out
  assign evict     = !match && pos_valid;
  assign ev_ex     = PageExW'(rd_data_q);
  assign pos_ex    = PosExW'(idx_q);

  // apb side
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegFramesInUse);
  assign prdata = (paddr[2] == RegFramesInUse) ? ApbDataW'(frames_q) : '0;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      LRU_IDLE: begin
        if (req_i.valid) state_d = LRU_SCAN;
      end
      LRU_SCAN: begin
        if (fin && out_free) state_d = LRU_IDLE;
      end
      default: state_d = LRU_IDLE;
    endcase
  end

  // state outputs: memory port control and input ready
  always_comb begin
    req_i.ready = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    rd_addr     = '0;
    unique case (state_q)
      LRU_IDLE: begin
        req_i.ready = 1'b1;
        rd_en       = req_i.valid;
      end
      LRU_SCAN: begin
        wr_en = !fin || out_free;
        if (!fin) begin
          rd_en   = 1'b1;
          rd_addr = IdxW'(idx_q + 1'b1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= LRU_IDLE;
    else         state_q <= state_d;
  end

  // page memory, one read and one write port, never the same address in a cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[idx_q] <= carry_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_data_q <= mem_q[rd_addr];
  end

  // walk registers
  always_ff @(posedge clk_i) begin
    if (state_q == LRU_IDLE && req_i.valid) begin
      page_q  <= page_in_ex[PAGE_BITS-1:0];
      carry_q <= page_in_ex[PAGE_BITS-1:0];
      idx_q   <= '0;
      last_q  <= last_cnt[IdxW-1:0];
    end else if (state_q == LRU_SCAN && !fin) begin
      carry_q <= rd_data_q;
      idx_q   <= IdxW'(idx_q + 1'b1);
    end
  end

  // frame count register, fill count and miss counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frames_q <= FramesInUseRst;
      count_q  <= '0;
      misses_q <= '0;
    end else if (cfg_wr) begin
      frames_q <= pwdata[FramesW-1:0];
      // entries beyond the new depth drop out silently
      if (count_q > depth_of(pwdata[FramesW-1:0])) count_q <= depth_of(pwdata[FramesW-1:0]);
    end else if (retire && !match) begin
      if (!evict) count_q <= count_q + 1'b1;
      if (misses_q != '1) misses_q <= misses_q + 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (retire) out_valid_q <= 1'b1;
    else if (rsp_o.ready) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (retire) begin
      out_q.hit           <= match;
      out_q.hit_position  <= match ? pos_ex[HitPosW-1:0] : '0;
      out_q.evicted_valid <= evict;
      out_q.evicted_page  <= evict ? ev_ex[PageNumW-1:0] : '0;
      if (!match && misses_q != '1) out_q.miss_count <= misses_q + 1'b1;
      else out_q.miss_count <= misses_q;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  `LRU_ASSERT_ALWAYS(a_fill_within_depth, count_q <= n_act, "fill count above active depth")
  `LRU_ASSERT_IMPL(a_walk_bound, state_q == LRU_SCAN, idx_q <= last_q,
    "walk ran past its last position")
  `LRU_ASSERT_NEXT(a_miss_count_monotonic, 1'b1, misses_q >= $past(misses_q),
    "miss counter went down")
  `LRU_ASSERT_IMPL(a_hit_no_evict, out_valid_q && out_q.hit, !out_q.evicted_valid,
    "hit reported with an eviction")

endmodule

`default_nettype wire

// ===== verif/lru_page_replacement_checker.sv =====
// checker for the lru page replacement unit: predicts every lookup and compares results
// watches the request and result channels and the apb port; depends on lru_pkg
module lru_page_replacement_checker import lru_pkg::*; #(
  parameter int FRAMES = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                psel_i,
  input  wire logic                penable_i,
  input  wire logic                pwrite_i,
  input  wire logic                pready_i,
  input  wire logic [ApbAddrW-1:0] paddr_i,
  input  wire logic [ApbDataW-1:0] pwdata_i,
  input  wire logic                req_valid_i,
  input  wire logic                req_ready_i,
  input  wire lru_req_t            req_payload_i,
  input  wire logic                rsp_valid_i,
  input  wire logic                rsp_ready_i,
  input  wire lru_rsp_t            rsp_payload_i,
  output int                       mismatch_count_o,
  output int                       outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [PageNumW-1:0] stack_page [FRAMES];
  logic                stack_vld  [FRAMES];
  logic [MissCntW-1:0] misses;
  logic [FramesW-1:0]  frames_reg;
  lru_rsp_t            predicted_lookups_q [$];

  function automatic int active_frames();
    int n;
    n = int'(frames_reg);
    if (n < 1) n = 1;
    if (n > FRAMES) n = FRAMES;
    return n;
  endfunction

  // move-to-front update of the recency stack
  function automatic lru_rsp_t lookup_page(input logic [PageNumW-1:0] pg);
    lru_rsp_t r;
    int       n;
    int       pos;
    bit       found;
    n     = active_frames();
    pos   = 0;
    found = 1'b0;
    r     = '0;
    for (int i = 0; i < n; i++) begin
      if (!found && stack_vld[i] && stack_page[i] == pg) begin
        found = 1'b1;
        pos   = i;
      end
    end
    if (found) begin
      for (int i = pos; i > 0; i--) begin
        stack_page[i] = stack_page[i-1];
        stack_vld[i]  = stack_vld[i-1];
      end
      r.hit          = 1'b1;
      r.hit_position = HitPosW'(pos);
    end else begin
      if (stack_vld[n-1]) begin
        r.evicted_valid = 1'b1;
        r.evicted_page  = stack_page[n-1];
      end
      for (int i = n - 1; i > 0; i--) begin
        stack_page[i] = stack_page[i-1];
        stack_vld[i]  = stack_vld[i-1];
      end
      if (misses != '1) misses = misses + 1'b1;
    end
    stack_page[0] = pg;
    stack_vld[0]  = 1'b1;
    r.miss_count  = misses;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lru_rsp_t exp_r;
    int       n;
    if (!rst_ni) begin
      for (int i = 0; i < FRAMES; i++) begin
        stack_page[i] = '0;
        stack_vld[i]  = 1'b0;
      end
      misses     = '0;
      frames_reg = FramesInUseRst;
      predicted_lookups_q.delete();
      mismatch_count_o = 0;
      outstanding_o    <= 0;
    end else begin
      // result transaction first: it always belongs to an earlier request
      if (rsp_valid_i && rsp_ready_i) begin
        if (predicted_lookups_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time,
                   rsp_payload_i);
          mismatch_count_o++;
        end else begin
          exp_r = predicted_lookups_q.pop_front();
          check_field("hit", 32'(exp_r.hit), 32'(rsp_payload_i.hit));
          check_field("hit_position", 32'(exp_r.hit_position),
                      32'(rsp_payload_i.hit_position));
          check_field("evicted_valid", 32'(exp_r.evicted_valid),
                      32'(rsp_payload_i.evicted_valid));
          check_field("evicted_page", 32'(exp_r.evicted_page),
                      32'(rsp_payload_i.evicted_page));
          check_field("miss_count", exp_r.miss_count, rsp_payload_i.miss_count);
        end
      end
      if (req_valid_i && req_ready_i) begin
        predicted_lookups_q.push_back(lookup_page(req_payload_i.page_number));
      end
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[ApbAddrW-1:2] == RegFramesInUse) begin
        frames_reg = pwdata_i[FramesW-1:0];
        n = active_frames();
        // entries beyond the new depth drop out without an eviction
        for (int i = n; i < FRAMES; i++) begin
          stack_vld[i]  = 1'b0;
          stack_page[i] = '0;
        end
      end
      outstanding_o <= predicted_lookups_q.size();
    end
  end

endmodule

// ===== verif/tb_lru_page_replacement_unit.sv =====
// testbench top for the lru page replacement unit: clock, reset, stimulus and verdict
// depends on lru_pkg, lru_stream_if, the unit itself and lru_page_replacement_checker
module tb_lru_page_replacement_unit import lru_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int Frames        = 8;
  localparam int ItemsPerPhase = 84;
  localparam int CycleLimit    = 600000;

  logic                clk_i;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  // percentage of cycles in which each side holds off
  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int outstanding;
  int cycle_cnt;

  lru_stream_if #(.PayloadT(lru_req_t)) req_if ();
  lru_stream_if #(.PayloadT(lru_rsp_t)) rsp_if ();

  lru_page_replacement_unit #(
    .FRAMES    (Frames),
    .PAGE_BITS (PageNumW)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .rsp_o   (rsp_if)
  );

  // checker sits beside the unit and only observes
  lru_page_replacement_checker #(
    .FRAMES (Frames)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel_i           (psel),
    .penable_i        (penable),
    .pwrite_i         (pwrite),
    .pready_i         (pready),
    .paddr_i          (paddr),
    .pwdata_i         (pwdata),
    .req_valid_i      (req_if.valid),
    .req_ready_i      (req_if.ready),
    .req_payload_i    (req_if.payload),
    .rsp_valid_i      (rsp_if.valid),
    .rsp_ready_i      (rsp_if.ready),
    .rsp_payload_i    (rsp_if.payload),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  // 2 ns clock period
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // result side: random back-pressure, ready driven from time zero
  initial begin
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog on the cycle count
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Verification failed");
    $finish;
  end

  // one request transaction; valid stays high across back-to-back transactions
  task automatic request_page(input logic [PageNumW-1:0] pg);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid   <= 1'b1;
    req_if.payload <= pg;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // stop sending until every predicted result has come back, then let the walk settle
  task automatic wait_lookups_done();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (Frames + 4) @(posedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic set_frames_in_use(input logic [FramesW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(RegFramesInUse) << 2;
    pwdata  <= ApbDataW'(val);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    logic [FramesW-1:0]  settings [3][5];
    logic [PageNumW-1:0] page_pool [$];
    logic [PageNumW-1:0] last_pg;
    logic [PageNumW-1:0] pg;
    int                  depth;
    int                  pool_size;
    int                  sel;

    settings = '{'{4'd8, 4'd1, 4'd0, 4'd15, 4'd3},
                 '{4'd2, 4'd9, 4'd5, 4'd8, 4'd6},
                 '{4'd7, 4'd4, 4'd1, 4'd8, 4'd12}};

    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    req_if.valid   = 1'b0;
    req_if.payload = '0;
    send_idle_pct  = 32;
    recv_idle_pct  = 51;
    last_pg        = '0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: page 0 misses although the empty stack holds zeros
    request_page(16'h0000);
    request_page(16'hFFFF);
    request_page(16'h0000);
    // fill all eight frames
    request_page(16'h8000);
    request_page(16'h0001);
    request_page(16'h1234);
    request_page(16'hABCD);
    request_page(16'h5555);
    request_page(16'hAAAA);
    // hit at the deepest position, then evictions of the oldest page
    request_page(16'hFFFF);
    request_page(16'h7FFF);
    request_page(16'h0000);
    request_page(16'h7FFF);
    wait_lookups_done();

    // shrinking the depth drops the deeper entries silently
    set_frames_in_use(4'd2);
    request_page(16'h0000);
    request_page(16'hAAAA);
    wait_lookups_done();

    // zero frames behaves as one
    set_frames_in_use(4'd0);
    request_page(16'hAAAA);
    request_page(16'h0000);
    wait_lookups_done();

    // a count above the built depth behaves as the full depth
    set_frames_in_use(4'd15);
    request_page(16'h0000);
    request_page(16'h0001);
    wait_lookups_done();

    // random part: three idling modes, five depth settings each
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin
          send_idle_pct = 32;
          recv_idle_pct = 51;
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 32;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      for (int s = 0; s < 5; s++) begin
        set_frames_in_use(settings[m][s]);
        depth = int'(settings[m][s]);
        if (depth < 1) depth = 1;
        if (depth > Frames) depth = Frames;

        // working set a little larger than the depth so hits and evictions mix
        page_pool.delete();
        pool_size = depth + 1 + $urandom_range(2);
        for (int p = 0; p < pool_size; p++) begin
          sel = $urandom_range(7);
          if (sel == 0) page_pool.push_back(16'h0000);
          else if (sel == 1) page_pool.push_back(16'hFFFF);
          else page_pool.push_back(PageNumW'($urandom));
        end

        for (int k = 0; k < ItemsPerPhase; k++) begin
          // hold off mid-phase until the unit has drained
          if (k == ItemsPerPhase / 2 && (s == 0 || $urandom_range(1) == 1)) begin
            wait_lookups_done();
          end
          sel = $urandom_range(99);
          if (sel < 70) pg = page_pool[$urandom_range(page_pool.size() - 1)];
          else if (sel < 85) pg = last_pg;
          else pg = PageNumW'($urandom);
          request_page(pg);
          last_pg = pg;
        end
        wait_lookups_done();
      end
    end

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
